// ===== hdl/wpl_pkg.sv =====
// Shared types, constants and arithmetic helpers of the wheel pair speed limiter.
`default_nettype none

package wpl_pkg;

  localparam int SPEED_W = 24;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 23;
  localparam int RATIO_W = FRAC_W + 1;
  localparam int IDX_W   = 2;

  // divider geometry: quotient as wide as a speed, numerator twice that
  localparam int DIV_Q_W = SPEED_W;
  localparam int DIV_D_W = SPEED_W + 1;
  localparam int NUM_W   = 2 * SPEED_W;

  localparam logic [RATIO_W-1:0] ONE_Q = RATIO_W'(1) << FRAC_W;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  localparam logic [CFG_W-1:0]   TRACK_RST = CFG_W'(32768);
  localparam logic [RATIO_W-1:0] RATIO_RST = '0;
  localparam logic [CFG_W-1:0]   MAXW_RST  = CFG_W'(65536);
  localparam logic [CFG_W-1:0]   MAXA_RST  = CFG_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_TRACK_WIDTH      = 2'd0,
    REG_MIN_INNER_RATIO  = 2'd1,
    REG_MAX_WHEEL_SPEED  = 2'd2,
    REG_MAX_ANGULAR_RATE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [SPEED_W-1:0] linear_command;
  } cmd_item_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [SPEED_W-1:0] left_target;
    logic signed [SPEED_W-1:0] right_target;
    logic signed [SPEED_W-1:0] linear_target;
    logic signed [SPEED_W-1:0] angular_target;
  } res_item_t;

  // one restoring divider lane: partial remainder, numerator bits still to
  // shift in, quotient so far, divisor
  typedef struct packed {
    logic [DIV_D_W-1:0] rem;
    logic [DIV_Q_W-1:0] low;
    logic [DIV_Q_W-1:0] quo;
    logic [DIV_D_W-1:0] den;
  } div_lane_t;

  // one quotient bit
  function automatic div_lane_t div_step(input div_lane_t x);
    div_lane_t          y;
    logic [DIV_D_W:0]   t;
    logic               qb;
    t  = {x.rem, x.low[DIV_Q_W-1]};
    qb = (t >= {1'b0, x.den});
    if (qb) begin
      t = t - {1'b0, x.den};
    end
    y.rem = t[DIV_D_W-1:0];
    y.low = {x.low[DIV_Q_W-2:0], 1'b0};
    y.quo = {x.quo[DIV_Q_W-2:0], qb};
    y.den = x.den;
    return y;
  endfunction

  // clamp a value two bits wider than a speed to the speed range
  function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPEED_W+1:0] x);
    logic [SPEED_W-1:0] y;
    if (x[SPEED_W+1] && (x[SPEED_W:SPEED_W-1] != 2'b11)) begin
      y = SPEED_MIN;
    end else if (!x[SPEED_W+1] && (x[SPEED_W:SPEED_W-1] != 2'b00)) begin
      y = SPEED_MAX;
    end else begin
      y = x[SPEED_W-1:0];
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/wheel_pair_linear_speed_limiter.sv =====
// Top level of the wheel pair linear speed limiter: full pipeline and output skid.
`default_nettype none

// Takes a proposed left/right wheel speed pair and a commanded centre speed V
// (signed Q8.16) and returns limited wheel targets, the centre speed and the
// yaw rate, or a beat with accepted low and all other fields zero when the
// command cannot be met. The turn component V*(L-R)/(L+R) (or (L-R)/2 when V
// is zero) is clamped to the least of wheel headroom, the yaw rate limit and
// the inner wheel ratio limit (nonzero V only); the yaw rate is 2*turn/track, saturated.
// Throughput is one beat per clock while the output skid stage is empty. The
// pipeline holds two
// chained banks of restoring dividers of one quotient bit per stage (24
// stages each): the turn and ratio-limit quotients run side by side, the yaw
// rate quotient follows. A one-entry skid stage behind the pipeline keeps it
// advancing while a result waits, until one more result drops into the skid.
// Configuration writes are always accepted and must only be issued while the block holds no work.
module wheel_pair_linear_speed_limiter (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cmd_valid,
  output logic                                  cmd_ready,
  input  wire wpl_pkg::cmd_item_t               cmd,
  output logic                                  res_valid,
  input  wire                                   res_ready,
  output wpl_pkg::res_item_t                    res,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [wpl_pkg::IDX_W-1:0]              cfg_index,
  input  wire [wpl_pkg::CFG_W-1:0]              cfg_data
);
  import wpl_pkg::*;

  // sideband carried through the first divider
  typedef struct packed {
    logic                      rej;
    logic                      vz;
    logic                      neg;
    logic signed [SPEED_W-1:0] v;
    logic signed [SPEED_W:0]   turn0;
    logic [SPEED_W-1:0]        lim;
  } sb1_t;

  // sideband carried through the yaw rate divider
  typedef struct packed {
    logic                      rej;
    logic                      aneg;
    logic                      ovf;
    logic signed [SPEED_W-1:0] v;
    logic [SPEED_W-1:0]        lt;
    logic [SPEED_W-1:0]        rt;
  } sb2_t;

  logic [CFG_W-1:0]   track_width;
  logic [RATIO_W-1:0] min_inner_ratio;
  logic [CFG_W-1:0]   max_wheel_speed;
  logic [CFG_W-1:0]   max_angular_rate;

  logic adv;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_width      <= TRACK_RST;
      min_inner_ratio  <= RATIO_RST;
      max_wheel_speed  <= MAXW_RST;
      max_angular_rate <= MAXA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRACK_WIDTH:      track_width      <= cfg_data;
        REG_MIN_INNER_RATIO:  min_inner_ratio  <= cfg_data[RATIO_W-1:0];
        REG_MAX_WHEEL_SPEED:  max_wheel_speed  <= cfg_data;
        REG_MAX_ANGULAR_RATE: max_angular_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- input register
  // Whole pipeline advances together; it only halts while the skid is full.
  logic      s0_valid;
  cmd_item_t s0_item;

  assign cmd_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= cmd;
    end
  end

  // ------------------------------------------- stage A: sums, signs, checks
  logic signed [SPEED_W-1:0] a_l, a_r, a_v;
  logic signed [SPEED_W:0]   a_sum_n, a_diff_n, a_turn0_n;
  logic [SPEED_W-1:0]        a_absv_n;
  logic                      a_vs, a_vz_n, a_sum_bad, a_l_bad, a_r_bad, a_rej_n;

  always_comb begin
    a_l       = s0_item.left_speed;
    a_r       = s0_item.right_speed;
    a_v       = s0_item.linear_command;
    a_sum_n   = (SPEED_W+1)'(a_l) + (SPEED_W+1)'(a_r);
    a_diff_n  = (SPEED_W+1)'(a_l) - (SPEED_W+1)'(a_r);
    a_absv_n  = a_v[SPEED_W-1] ? (~a_v + SPEED_W'(1)) : a_v;
    a_vs      = a_v[SPEED_W-1];
    a_vz_n    = (a_v == '0);
    // pair must agree in sign with the command
    a_sum_bad = (a_sum_n == '0) || (a_sum_n[SPEED_W] != a_vs);
    a_l_bad   = (a_l != '0) && (a_l[SPEED_W-1] != a_vs);
    a_r_bad   = (a_r != '0) && (a_r[SPEED_W-1] != a_vs);
    a_rej_n   = (track_width == '0) || (max_wheel_speed == '0) ||
                (min_inner_ratio > ONE_Q) ||
                (a_absv_n > {1'b0, max_wheel_speed}) ||
                (!a_vz_n && (a_sum_bad || a_l_bad || a_r_bad));
    // halve toward zero
    a_turn0_n = (a_diff_n + $signed({{SPEED_W{1'b0}}, a_diff_n[SPEED_W]})) >>> 1;
  end

  logic                      a_valid, a_rej, a_vz;
  logic signed [SPEED_W-1:0] a_vq;
  logic signed [SPEED_W:0]   a_sum, a_diff, a_turn0;
  logic [SPEED_W-1:0]        a_absv, a_lima;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rej   <= a_rej_n;
      a_vz    <= a_vz_n;
      a_vq    <= a_v;
      a_sum   <= a_sum_n;
      a_diff  <= a_diff_n;
      a_turn0 <= a_turn0_n;
      a_absv  <= a_absv_n;
      a_lima  <= {1'b0, max_wheel_speed} - a_absv_n;
    end
  end

  // ------------------------------------------------------ stage B: products
  logic signed [2*SPEED_W:0]      b_prod_t_n;
  logic [SPEED_W+RATIO_W-1:0]     b_prod_c_n;
  logic [2*CFG_W-1:0]             b_prod_l_n;

  always_comb begin
    b_prod_t_n = (2*SPEED_W+1)'(a_vq) * (2*SPEED_W+1)'(a_diff);
    b_prod_c_n = (SPEED_W+RATIO_W)'(a_absv) *
                 (SPEED_W+RATIO_W)'(ONE_Q - min_inner_ratio);
    b_prod_l_n = (2*CFG_W)'(max_angular_rate) * (2*CFG_W)'(track_width);
  end

  logic                             b_valid, b_rej, b_vz;
  logic signed [SPEED_W-1:0]        b_v;
  logic signed [SPEED_W:0]          b_sum, b_turn0;
  logic [SPEED_W-1:0]               b_lima;
  logic signed [2*SPEED_W:0]        b_prod_t;
  logic [SPEED_W+RATIO_W-1:0]       b_prod_c;
  logic [2*CFG_W-FRAC_W-2:0]        b_limb;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_rej    <= a_rej;
      b_vz     <= a_vz;
      b_v      <= a_vq;
      b_sum    <= a_sum;
      b_turn0  <= a_turn0;
      b_lima   <= a_lima;
      b_prod_t <= b_prod_t_n;
      b_prod_c <= b_prod_c_n;
      // rate * track / 2, back to Q8.16
      b_limb   <= b_prod_l_n[2*CFG_W-1:FRAC_W+1];
    end
  end

  // ------------------------------- stage C: magnitudes, load divider lanes
  logic      d1_valid [0:DIV_Q_W];
  sb1_t      d1_sb    [0:DIV_Q_W];
  div_lane_t d1_t     [0:DIV_Q_W];
  div_lane_t d1_c     [0:DIV_Q_W];

  logic [2*SPEED_W:0]  c_mag_full;
  logic [SPEED_W:0]    c_abs_sum;
  logic [NUM_W-1:0]    c_num_c;
  sb1_t                c_sb_n;
  div_lane_t           c_t_n, c_c_n;

  always_comb begin
    c_mag_full = b_prod_t[2*SPEED_W] ? (~b_prod_t + 1'b1) : b_prod_t;
    c_abs_sum  = b_sum[SPEED_W] ? (~b_sum + 1'b1) : b_sum;
    c_num_c    = NUM_W'(b_prod_c);

    c_sb_n.rej   = b_rej;
    c_sb_n.vz    = b_vz;
    c_sb_n.neg   = b_prod_t[2*SPEED_W] ^ b_sum[SPEED_W];
    c_sb_n.v     = b_v;
    c_sb_n.turn0 = b_turn0;
    c_sb_n.lim   = (b_limb > (2*CFG_W-FRAC_W-1)'(b_lima)) ? b_lima
                                                          : b_limb[SPEED_W-1:0];

    c_t_n.rem = DIV_D_W'(c_mag_full[NUM_W-1:DIV_Q_W]);
    c_t_n.low = c_mag_full[DIV_Q_W-1:0];
    c_t_n.quo = '0;
    c_t_n.den = c_abs_sum;

    c_c_n.rem = DIV_D_W'(c_num_c[NUM_W-1:DIV_Q_W]);
    c_c_n.low = c_num_c[DIV_Q_W-1:0];
    c_c_n.quo = '0;
    c_c_n.den = DIV_D_W'(ONE_Q) + DIV_D_W'(min_inner_ratio);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid[0] <= 1'b0;
    end else if (adv) begin
      d1_valid[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_sb[0] <= c_sb_n;
      d1_t[0]  <= c_t_n;
      d1_c[0]  <= c_c_n;
    end
  end

  // ------------------------ turn and ratio-limit dividers, one bit a stage
  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_div1
    always_ff @(posedge clk) begin
      if (rst) begin
        d1_valid[k+1] <= 1'b0;
      end else if (adv) begin
        d1_valid[k+1] <= d1_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d1_sb[k+1] <= d1_sb[k];
        d1_t[k+1]  <= div_step(d1_t[k]);
        d1_c[k+1]  <= div_step(d1_c[k]);
      end
    end
  end

  // -------------------------------- stage E: signed turn and final limit
  sb1_t                    e_in;
  logic signed [SPEED_W:0] e_turnq, e_turn_n;
  logic [SPEED_W-1:0]      e_limit_n;

  always_comb begin
    e_in      = d1_sb[DIV_Q_W];
    e_turnq   = e_in.neg ? -$signed({1'b0, d1_t[DIV_Q_W].quo})
                         :  $signed({1'b0, d1_t[DIV_Q_W].quo});
    e_turn_n  = e_in.vz ? e_in.turn0 : e_turnq;
    // ratio limit applies only to a moving command
    e_limit_n = (!e_in.vz && (d1_c[DIV_Q_W].quo < e_in.lim)) ? d1_c[DIV_Q_W].quo
                                                           : e_in.lim;
  end

  logic                      e_valid, e_rej;
  logic signed [SPEED_W-1:0] e_v;
  logic signed [SPEED_W:0]   e_turn;
  logic [SPEED_W-1:0]        e_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d1_valid[DIV_Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_rej   <= e_in.rej;
      e_v     <= e_in.v;
      e_turn  <= e_turn_n;
      e_limit <= e_limit_n;
    end
  end

  // ------------------ stage F: clamp, wheel targets, load yaw rate divider
  logic      d2_valid [0:DIV_Q_W];
  sb2_t      d2_sb    [0:DIV_Q_W];
  div_lane_t d2_a     [0:DIV_Q_W];

  logic signed [SPEED_W:0]   f_lim, f_turn;
  logic [SPEED_W:0]          f_mag;
  logic [NUM_W-1:0]          f_num;
  sb2_t                      f_sb_n;
  div_lane_t                 f_a_n;

  always_comb begin
    f_lim = $signed({1'b0, e_limit});
    priority if (e_turn > f_lim) begin
      f_turn = f_lim;
    end else if (e_turn < -f_lim) begin
      f_turn = -f_lim;
    end else begin
      f_turn = e_turn;
    end
    f_mag = f_turn[SPEED_W] ? (~f_turn + 1'b1) : f_turn;
    // |turn| * 2 in Q8.16, pre-shifted by the fraction for the quotient
    f_num = NUM_W'(f_mag) << (FRAC_W + 1);

    f_sb_n.rej  = e_rej;
    f_sb_n.aneg = f_turn[SPEED_W];
    f_sb_n.ovf  = ({1'b0, f_num[NUM_W-1:DIV_Q_W]} >= DIV_D_W'(track_width));
    f_sb_n.v    = e_v;
    f_sb_n.lt   = sat_speed((SPEED_W+2)'(e_v) + (SPEED_W+2)'(f_turn));
    f_sb_n.rt   = sat_speed((SPEED_W+2)'(e_v) - (SPEED_W+2)'(f_turn));

    f_a_n.rem = DIV_D_W'(f_num[NUM_W-1:DIV_Q_W]);
    f_a_n.low = f_num[DIV_Q_W-1:0];
    f_a_n.quo = '0;
    f_a_n.den = DIV_D_W'(track_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_valid[0] <= 1'b0;
    end else if (adv) begin
      d2_valid[0] <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_sb[0] <= f_sb_n;
      d2_a[0]  <= f_a_n;
    end
  end

  // ------------------------------------------------- yaw rate divider
  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_div2
    always_ff @(posedge clk) begin
      if (rst) begin
        d2_valid[k+1] <= 1'b0;
      end else if (adv) begin
        d2_valid[k+1] <= d2_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d2_sb[k+1] <= d2_sb[k];
        d2_a[k+1]  <= div_step(d2_a[k]);
      end
    end
  end

  // ---------------------------------- stage H: saturate yaw rate, pack beat
  sb2_t               h_in;
  logic [SPEED_W-1:0] h_q, h_ang;
  res_item_t          h_item_n;

  always_comb begin
    h_in = d2_sb[DIV_Q_W];
    h_q  = d2_a[DIV_Q_W].quo;
    if (h_in.aneg) begin
      h_ang = (h_in.ovf || (h_q > SPEED_MIN)) ? SPEED_MIN : (~h_q + 1'b1);
    end else begin
      h_ang = (h_in.ovf || h_q[SPEED_W-1]) ? SPEED_MAX : h_q;
    end
    if (h_in.rej) begin
      h_item_n = '0;
    end else begin
      h_item_n.accepted       = 1'b1;
      h_item_n.left_target    = h_in.lt;
      h_item_n.right_target   = h_in.rt;
      h_item_n.linear_target  = h_in.v;
      h_item_n.angular_target = h_ang;
    end
  end

  logic      h_valid;
  res_item_t h_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (adv) begin
      h_valid <= d2_valid[DIV_Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_item <= h_item_n;
    end
  end

  // ------------------------------------------------ output register + skid
  // Hold the pipeline only while the skid holds a beat; a beat that finds
  // the output register busy drops into the skid.
  logic      skid_valid;
  res_item_t skid_item;
  logic      arrive;

  assign adv    = !skid_valid;
  assign arrive = adv && h_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_ready || !res_valid) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= arrive;
      end
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready || !res_valid) begin
      if (skid_valid) begin
        res <= skid_item;
      end else if (arrive) begin
        res <= h_item;
      end
    end else if (arrive) begin
      skid_item <= h_item;
    end
  end

  // ---------------------------------------------------------- assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds a beat while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    $fell(skid_valid) |-> res_valid)
    else $error("skid emptied without moving its beat to the output");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.accepted) |->
      (res.left_target == '0 && res.right_target == '0 &&
       res.linear_target == '0 && res.angular_target == '0))
    else $error("rejected beat carries nonzero fields");

  a_wheels_center: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.accepted) |->
      ((SPEED_W+1)'(res.left_target) + (SPEED_W+1)'(res.right_target) ==
       ((SPEED_W+1)'(res.linear_target) <<< 1)))
    else $error("wheel targets do not average to the linear target");

endmodule

`default_nettype wire
